/* rtl/vmd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vmd_pkg: shared types and constants of the message deframer
// Result kinds, status codes, header byte positions and queue sizing.
// ----------------------------------------------------------------------------
package vmd_pkg;

    typedef enum logic [1:0] {
        KIND_HDR = 2'd0,
        KIND_V1  = 2'd1,
        KIND_V2  = 2'd2,
        KIND_ERR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_HDR_CRC  = 3'd1,
        ST_FRM_CRC  = 3'd2,
        ST_BAD_VER  = 3'd3,
        ST_LENGTH   = 3'd4,
        ST_V2_CRC   = 3'd5
    } t_status;

    localparam int POS_W = 11;
    localparam logic [POS_W-1:0] POS_MAX = 11'd2047;

    // header byte positions
    localparam logic [POS_W-1:0] P_SYNC     = 11'd0;
    localparam logic [POS_W-1:0] P_DEST_LO  = 11'd1;
    localparam logic [POS_W-1:0] P_DEST_HI  = 11'd2;
    localparam logic [POS_W-1:0] P_SRC_LO   = 11'd3;
    localparam logic [POS_W-1:0] P_SRC_HI   = 11'd4;
    localparam logic [POS_W-1:0] P_VERSION  = 11'd5;
    localparam logic [POS_W-1:0] P_CMD_LO   = 11'd6;
    localparam logic [POS_W-1:0] P_CMD_HI   = 11'd7;
    localparam logic [POS_W-1:0] P_FRAMES   = 11'd8;
    localparam logic [POS_W-1:0] P_HDR_CRC  = 11'd9;
    localparam logic [POS_W-1:0] P_V2_DLAST = 11'd13;
    localparam logic [POS_W-1:0] P_V2_SEPT  = 11'd14;
    localparam logic [POS_W-1:0] P_V2_CRC   = 11'd15;

    localparam logic [6:0] CSUM_INIT = 7'h7F;
    localparam logic [3:0] VER_V1    = 4'd1;
    localparam logic [3:0] VER_V2    = 4'd2;

    // frame layout: four data bytes, septet, checksum
    localparam logic [2:0] FRM_SEPT_IDX = 3'd4;
    localparam logic [2:0] FRM_CRC_IDX  = 3'd5;
    localparam int         DATA_DEPTH   = 6;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_LW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        t_kind        kind;
        t_status      status;
        logic [15:0]  dest;
        logic [15:0]  src;
        logic [15:0]  cmd;
        logic [7:0]   frame;
        logic [31:0]  payload;
        logic [15:0]  pid;
        logic         last;
    } t_result;

    // up to two result words produced by one message byte
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage
`default_nettype wire

/* rtl/vmd_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vmd_if: valid/ready channels of the message deframer
// Byte input channel and result output channel.
// ----------------------------------------------------------------------------
interface vmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       msg_start;
    logic       msg_end;

    modport source (output valid, rx_byte, msg_start, msg_end, input ready);
    modport sink   (input valid, rx_byte, msg_start, msg_end, output ready);
endinterface

interface vmd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [2:0]  status;
    logic [15:0] dest_address;
    logic [15:0] src_address;
    logic [15:0] command_word;
    logic [7:0]  frame_number;
    logic [31:0] payload_word;
    logic [15:0] point_id;
    logic        last_of_message;

    modport source (output valid, result_kind, status, dest_address, src_address,
                    command_word, frame_number, payload_word, point_id,
                    last_of_message, input ready);
    modport sink   (input valid, result_kind, status, dest_address, src_address,
                    command_word, frame_number, payload_word, point_id,
                    last_of_message, output ready);
endinterface
`default_nettype wire

/* rtl/vmd_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vmd_decode: byte register, message state and per-byte decode
// Registers each accepted byte, then updates the message state and forms
// the result words that byte causes.
// ----------------------------------------------------------------------------
module vmd_decode (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_msg_start,
    input  wire logic          i_msg_end,
    output vmd_pkg::t_push     o_push
);
    import vmd_pkg::*;

    // input register
    logic             r_in_valid;
    logic [7:0]       r_byte;
    logic             r_st;
    logic             r_en;

    // message state
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [6:0]       r_csum,  n_csum;
    logic [15:0]      r_dest,  n_dest;
    logic [15:0]      r_src,   n_src;
    logic [15:0]      r_cmd,   n_cmd;
    logic [3:0]       r_ver,   n_ver;
    logic [7:0]       r_fexp,  n_fexp;
    logic [7:0]       r_fcnt,  n_fcnt;
    logic [2:0]       r_fidx,  n_fidx;
    logic             r_lat,   n_lat;
    logic [6:0]       r_data [DATA_DEPTH];

    logic             d_we;
    logic [2:0]       d_idx;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] last_pos;
    t_status          err;
    logic             complete;
    logic             a_vld, b_vld;
    t_result          res_a, res_b, res_e;
    logic [6:0]       sep;
    logic [7:0]       e_fexp;

    function automatic t_result mk(t_kind k, t_status s, logic [15:0] d,
                                   logic [15:0] sr, logic [15:0] c, logic [7:0] f,
                                   logic [31:0] pl, logic [15:0] id);
        t_result r;
        r.kind    = k;
        r.status  = s;
        r.dest    = d;
        r.src     = sr;
        r.cmd     = c;
        r.frame   = f;
        r.payload = pl;
        r.pid     = id;
        r.last    = 1'b0;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_take;
        end
        if (i_take) begin
            r_byte <= i_rx_byte;
            r_st   <= i_msg_start;
            r_en   <= i_msg_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_csum <= CSUM_INIT;
            r_dest <= '0;
            r_src  <= '0;
            r_cmd  <= '0;
            r_ver  <= '0;
            r_fexp <= '0;
            r_fcnt <= '0;
            r_fidx <= '0;
            r_lat  <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_csum <= n_csum;
            r_dest <= n_dest;
            r_src  <= n_src;
            r_cmd  <= n_cmd;
            r_ver  <= n_ver;
            r_fexp <= n_fexp;
            r_fcnt <= n_fcnt;
            r_fidx <= n_fidx;
            r_lat  <= n_lat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_data[d_idx] <= r_byte[6:0];
        end
    end

    // frame count as seen by this byte, before any update at the count byte
    assign e_fexp   = (r_in_valid && r_st) ? 8'd0 : r_fexp;
    assign last_pos = P_HDR_CRC + {1'b0, e_fexp, 2'b00} + {2'b00, e_fexp, 1'b0};

    always_comb begin
        n_pos    = r_pos;
        n_csum   = r_csum;
        n_dest   = r_dest;
        n_src    = r_src;
        n_cmd    = r_cmd;
        n_ver    = r_ver;
        n_fexp   = r_fexp;
        n_fcnt   = r_fcnt;
        n_fidx   = r_fidx;
        n_lat    = r_lat;
        d_we     = 1'b0;
        d_idx    = '0;
        p        = '0;
        err      = ST_OK;
        complete = 1'b0;
        a_vld    = 1'b0;
        b_vld    = 1'b0;
        sep      = '0;
        res_a    = '0;
        res_b    = '0;
        if (r_in_valid) begin
            if (r_st) begin
                n_pos  = '0;
                n_csum = CSUM_INIT;
                n_dest = '0;
                n_src  = '0;
                n_cmd  = '0;
                n_ver  = '0;
                n_fexp = '0;
                n_fcnt = '0;
                n_lat  = 1'b0;
            end
            p = n_pos;
            if (n_pos != POS_MAX) begin
                n_pos = n_pos + 1'b1;
            end
            if (!n_lat) begin
                if (p == P_SYNC) begin
                    // sync byte: nothing to capture
                end else if (p <= P_CMD_HI) begin
                    n_csum = n_csum - r_byte[6:0];
                    case (p)
                        P_DEST_LO: n_dest[7:0]  = r_byte;
                        P_DEST_HI: n_dest[15:8] = r_byte;
                        P_SRC_LO:  n_src[7:0]   = r_byte;
                        P_SRC_HI:  n_src[15:8]  = r_byte;
                        P_VERSION: begin
                            n_ver = r_byte[7:4];
                            if (!(n_ver inside {VER_V1, VER_V2})) begin
                                err = ST_BAD_VER;
                            end
                        end
                        P_CMD_LO:  n_cmd[7:0]   = r_byte;
                        default:   n_cmd[15:8]  = r_byte;
                    endcase
                end else if (n_ver == VER_V1) begin
                    if (p == P_FRAMES) begin
                        n_csum = n_csum - r_byte[6:0];
                        n_fexp = r_byte;
                    end else if (p == P_HDR_CRC) begin
                        if (r_byte != {1'b0, n_csum}) begin
                            err = ST_HDR_CRC;
                        end else begin
                            a_vld = 1'b1;
                            res_a = mk(KIND_HDR, ST_OK, n_dest, n_src, n_cmd, n_fexp,
                                       '0, '0);
                        end
                        n_csum = CSUM_INIT;
                        n_fidx = '0;
                    end else if (p > last_pos) begin
                        err = ST_LENGTH;
                    end else if (n_fidx != FRM_CRC_IDX) begin
                        d_we   = 1'b1;
                        d_idx  = n_fidx;
                        n_csum = n_csum - r_byte[6:0];
                        n_fidx = n_fidx + 1'b1;
                    end else begin
                        if (r_byte != {1'b0, n_csum}) begin
                            err = ST_FRM_CRC;
                        end else begin
                            sep   = r_data[FRM_SEPT_IDX];
                            a_vld = 1'b1;
                            res_a = mk(KIND_V1, ST_OK, n_dest, n_src, n_cmd, n_fcnt,
                                       {sep[3], r_data[3], sep[2], r_data[2],
                                        sep[1], r_data[1], sep[0], r_data[0]}, '0);
                            n_fcnt = n_fcnt + 1'b1;
                        end
                        n_csum = CSUM_INIT;
                        n_fidx = '0;
                    end
                    if (err == ST_OK && p == last_pos) begin
                        complete = 1'b1;
                    end
                end else begin
                    if (p <= P_V2_DLAST) begin
                        d_we   = 1'b1;
                        d_idx  = p[2:0];
                        n_csum = n_csum - r_byte[6:0];
                    end else if (p == P_V2_SEPT) begin
                        n_fexp = {1'b0, r_byte[6:0]};
                        n_csum = n_csum - r_byte[6:0];
                    end else if (p == P_V2_CRC) begin
                        if (r_byte != {1'b0, n_csum}) begin
                            err = ST_V2_CRC;
                        end else begin
                            sep   = n_fexp[6:0];
                            a_vld = 1'b1;
                            b_vld = 1'b1;
                            res_a = mk(KIND_HDR, ST_OK, n_dest, n_src, n_cmd, '0, '0, '0);
                            res_b = mk(KIND_V2, ST_OK, n_dest, n_src, n_cmd, '0,
                                       {sep[5], r_data[5], sep[4], r_data[4],
                                        sep[3], r_data[3], sep[2], r_data[2]},
                                       {sep[1], r_data[1], sep[0], r_data[0]});
                            complete = 1'b1;
                        end
                    end else begin
                        err = ST_LENGTH;
                    end
                end
                // end mark must land on the expected last byte
                if (err == ST_OK && r_en) begin
                    if (complete && a_vld) begin
                        if (b_vld) begin
                            res_b.last = 1'b1;
                        end else begin
                            res_a.last = 1'b1;
                        end
                    end else begin
                        err = ST_LENGTH;
                    end
                end
                if (err != ST_OK || r_en) begin
                    n_lat = 1'b1;
                end
            end
        end
    end

    always_comb begin
        res_e      = mk(KIND_ERR, err, n_dest, n_src, n_cmd, n_fcnt, '0, '0);
        res_e.last = 1'b1;
        o_push     = '0;
        if (err != ST_OK) begin
            if (a_vld) begin
                o_push.cnt = 2'd2;
                o_push.r0  = res_a;
                o_push.r1  = res_e;
            end else begin
                o_push.cnt = 2'd1;
                o_push.r0  = res_e;
            end
        end else if (b_vld) begin
            o_push.cnt = 2'd2;
            o_push.r0  = res_a;
            o_push.r1  = res_b;
        end else if (a_vld) begin
            o_push.cnt = 2'd1;
            o_push.r0  = res_a;
        end
    end

endmodule
`default_nettype wire

/* rtl/vmd_res_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vmd_res_fifo: result queue
// Takes up to two result words per cycle, hands out one per cycle.
// ----------------------------------------------------------------------------
module vmd_res_fifo (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire vmd_pkg::t_push           i_push,
    input  wire logic                     i_pop,
    output logic [vmd_pkg::FIFO_LW-1:0]   o_level,
    output vmd_pkg::t_result              o_head
);
    import vmd_pkg::*;

    t_result            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, n_wp;
    logic [FIFO_AW-1:0] r_rp, n_rp;
    logic [FIFO_LW-1:0] r_lvl, n_lvl;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + 1'b1] <= i_push.r1;
        end
    end

    always_comb begin
        n_wp  = r_wp + FIFO_AW'(i_push.cnt);
        n_rp  = r_rp + FIFO_AW'(i_pop);
        n_lvl = r_lvl + FIFO_LW'(i_push.cnt) - FIFO_LW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_lvl <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_lvl <= n_lvl;
        end
    end

    assign o_level = r_lvl;
    assign o_head  = r_mem[r_rp];

endmodule
`default_nettype wire

/* rtl/vbus_message_deframer_top.sv */
`default_nettype none
// Path: a byte accepted by the input is held in the byte register, and its
//   results reach the output channel through the result queue.
// Throughput: one byte per cycle while the queue has room; the input is held off
//   until the four-entry result queue drains enough for two more words.
// Reset: synchronous, active low; holds the input off, clears the message
//   state and empties the queue. Stored data bytes are not reset.
// ----------------------------------------------------------------------------
// vbus_message_deframer_top: field-bus message deframer
// Checks header and frame checksums, restores payload bytes from the septet
// and reports header, payload, data point and error results.
// ----------------------------------------------------------------------------
module vbus_message_deframer_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vmd_in_if.sink     i_in,
    vmd_out_if.source  o_out
);
    import vmd_pkg::*;

    logic               w_take;
    logic               w_pop;
    t_push              w_push;
    t_result            w_head;
    logic [FIFO_LW-1:0] w_level;
    logic [FIFO_LW:0]   w_after;

    // Decode stage: byte register, message state, result formation.
    vmd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_rx_byte   (i_in.rx_byte),
        .i_msg_start (i_in.msg_start),
        .i_msg_end   (i_in.msg_end),
        .o_push      (w_push)
    );

    // Result queue between the decode stage and the output channel.
    vmd_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_level (w_level),
        .o_head  (w_head)
    );

    // Queue fill once the byte in the decode stage has landed; a new byte may
    // enter only if two more words still fit behind that. Hold the input off
    // while reset is applied.
    assign w_after    = {1'b0, w_level} + (FIFO_LW + 1)'(w_push.cnt);
    assign i_in.ready = i_rst_n && (w_after <= (FIFO_LW + 1)'(FIFO_DEPTH - 2));
    assign w_take     = i_in.valid && i_in.ready;

    // Output channel straight from the queue head.
    assign o_out.valid           = (w_level != '0);
    assign w_pop                 = o_out.valid && o_out.ready;
    assign o_out.result_kind     = w_head.kind;
    assign o_out.status          = w_head.status;
    assign o_out.dest_address    = w_head.dest;
    assign o_out.src_address     = w_head.src;
    assign o_out.command_word    = w_head.cmd;
    assign o_out.frame_number    = w_head.frame;
    assign o_out.payload_word    = w_head.payload;
    assign o_out.point_id        = w_head.pid;
    assign o_out.last_of_message = w_head.last;

    // Queue never overflows when the decode stage pushes.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt != 2'd0) |-> (w_after <= (FIFO_LW + 1)'(FIFO_DEPTH)))
        else $error("result queue overflow");

    // An error word always closes its message.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.result_kind == KIND_ERR) |-> o_out.last_of_message)
        else $error("error result without last mark");

    // With two words, the first is never the error.
    a_err_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt == 2'd2) |-> (w_push.r0.kind != KIND_ERR))
        else $error("error pushed ahead of a normal result");

    // An accepted byte enters the decode stage through the byte register, so a
    // push only ever follows an accept in the cycle before.
    a_push_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt != 2'd0) |-> $past(w_take))
        else $error("result pushed without a byte");

endmodule
`default_nettype wire
